// ===== hw/rtl/utf8_stream_decoder_with_replacement_macros.svh =====
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_WITH_REPLACEMENT_MACROS_SVH
`define UTF8_STREAM_DECODER_WITH_REPLACEMENT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define U8D_ASSERT_NOW(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define U8D_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hw/rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Constants and types shared by the decoder and its checker.
// ----------------------------------------------------------------------------
package utf8d_pkg;

    localparam int CP_W = 21;

    // Code point constants
    localparam logic [CP_W-1:0] REPL_CHAR  = 21'h00FFFD;
    localparam logic [CP_W-1:0] MAX_CP     = 21'h10FFFF;
    localparam logic [CP_W-1:0] MIN_CP_2   = 21'h000080;
    localparam logic [CP_W-1:0] MIN_CP_3   = 21'h000800;
    localparam logic [CP_W-1:0] MIN_CP_4   = 21'h010000;
    localparam logic [CP_W-1:0] SURR_LO    = 21'h00D800;
    localparam logic [CP_W-1:0] SURR_HI    = 21'h00DFFF;

    // Lead byte masks and patterns
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_PAT   = 8'h80;
    localparam logic [7:0] TERM_BYTE  = 8'h00;

    // Open sequence length codes
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_2    = 3'd2;
    localparam logic [2:0] SEQ_3    = 3'd3;
    localparam logic [2:0] SEQ_4    = 3'd4;

    // Results produced by one input byte: a run of replacements, then an
    // optional tail item (character, bad lead replacement or end marker)
    typedef struct packed {
        logic [2:0]      rep_cnt;
        logic            tail_vld;
        logic [CP_W-1:0] tail_cp;
        logic            tail_rep;
        logic            tail_eos;
    } t_burst;

endpackage

// ===== hw/rtl/utf8_stream_decoder_with_replacement.sv =====
// ----------------------------------------------------------------------------
// UTF-8 stream decoder with replacement
// Decodes a byte stream into Unicode scalar values, substituting U+FFFD.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: i_valid / i_data_byte, with o_stall back to the sender.
//   A zero byte terminates the string: any open sequence is flushed as
//   U+FFFD items and an end marker (codepoint 0, o_end_of_string 1) follows.
//   Output channel: o_valid / o_codepoint / o_replaced / o_end_of_string,
//   with i_stall from the receiver.
//   An accepted byte waits in the input register and then moves into the
//   result register, from which its results are shown.
//   Throughput: one byte per cycle while each byte yields at most one
//   result and the receiver does not stall. A byte that yields k results (up
//   to four, on errors or at the terminator) holds the result register until
//   all k are taken, and the input register buffers one more byte meanwhile.
//   When the receiver stalls, the shown result holds and the input side
//   stalls once the input register is full.
//   Reset (i_rst_n low at a clock edge) empties both registers and closes
//   any open sequence.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_with_replacement (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    output logic        o_stall,
    output logic        o_valid,
    output logic [20:0] o_codepoint,
    output logic        o_replaced,
    output logic        o_end_of_string,
    input  logic        i_stall
);

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Decoder state
    logic [2:0]  r_seq_len;
    logic [1:0]  r_taken;
    logic [20:0] r_partial;
    logic [2:0]  n_seq_len;
    logic [1:0]  n_taken;
    logic [20:0] n_partial;

    // Result register
    utf8d_pkg::t_burst r_burst;
    utf8d_pkg::t_burst n_burst;

    logic        out_take;
    logic        burst_last;
    logic        move;
    logic        in_take;

    logic        seq_open;
    logic        is_cont;
    logic [2:0]  flush_cnt;
    logic [20:0] cont_pv;
    logic [1:0]  cont_taken;
    logic        cont_last;
    logic        cont_ok;

    // Output drain and handshake
    assign o_valid    = (r_burst.rep_cnt != 3'd0) || r_burst.tail_vld;
    assign out_take   = o_valid && !i_stall;
    assign burst_last = ((r_burst.rep_cnt == 3'd0) && r_burst.tail_vld)
                     || ((r_burst.rep_cnt == 3'd1) && !r_burst.tail_vld);
    assign move       = r_in_valid && (!o_valid || (out_take && burst_last));
    assign o_stall    = r_in_valid && !move;
    assign in_take    = i_valid && !o_stall;

    // Show replacements first, then the tail item
    always_comb begin
        if (r_burst.rep_cnt != 3'd0) begin
            o_codepoint     = utf8d_pkg::REPL_CHAR;
            o_replaced      = 1'b1;
            o_end_of_string = 1'b0;
        end else begin
            o_codepoint     = r_burst.tail_cp;
            o_replaced      = r_burst.tail_rep;
            o_end_of_string = r_burst.tail_eos;
        end
    end

    // Continuation path: shift in six payload bits and check the value
    assign seq_open   = (r_seq_len == utf8d_pkg::SEQ_2) || (r_seq_len == utf8d_pkg::SEQ_3)
                     || (r_seq_len == utf8d_pkg::SEQ_4);
    assign is_cont    = (r_in_byte & utf8d_pkg::CONT_MASK) == utf8d_pkg::CONT_PAT;
    assign flush_cnt  = seq_open ? ({1'b0, r_taken} + 3'd1) : 3'd0;
    assign cont_pv    = {r_partial[14:0], r_in_byte[5:0]};
    assign cont_taken = r_taken + 2'd1;
    assign cont_last  = ({1'b0, cont_taken} + 3'd1) >= r_seq_len;

    always_comb begin
        case (r_seq_len)
            utf8d_pkg::SEQ_2: cont_ok = cont_pv >= utf8d_pkg::MIN_CP_2;
            utf8d_pkg::SEQ_3: cont_ok = (cont_pv >= utf8d_pkg::MIN_CP_3)
                                     && !((cont_pv >= utf8d_pkg::SURR_LO)
                                     && (cont_pv <= utf8d_pkg::SURR_HI));
            default:          cont_ok = (cont_pv >= utf8d_pkg::MIN_CP_4)
                                     && (cont_pv <= utf8d_pkg::MAX_CP);
        endcase
    end

    // Decode the byte in the input register into a burst and next state
    always_comb begin
        n_burst   = '0;
        n_seq_len = r_seq_len;
        n_taken   = r_taken;
        n_partial = r_partial;
        if (r_in_byte == utf8d_pkg::TERM_BYTE) begin
            // Flush open sequence, then end marker
            n_burst.rep_cnt  = flush_cnt;
            n_burst.tail_vld = 1'b1;
            n_burst.tail_eos = 1'b1;
            n_seq_len        = utf8d_pkg::SEQ_NONE;
            n_taken          = 2'd0;
            n_partial        = '0;
        end else if (!seq_open || !is_cont) begin
            // Flush anything open and decode the byte as a new lead
            n_burst.rep_cnt = flush_cnt;
            n_seq_len       = utf8d_pkg::SEQ_NONE;
            n_taken         = 2'd0;
            n_partial       = '0;
            if (!r_in_byte[7]) begin
                n_burst.tail_vld = 1'b1;
                n_burst.tail_cp  = {13'd0, r_in_byte};
            end else if ((r_in_byte & utf8d_pkg::LEAD2_MASK) == utf8d_pkg::LEAD2_PAT) begin
                n_seq_len = utf8d_pkg::SEQ_2;
                n_partial = {16'd0, r_in_byte[4:0]};
            end else if ((r_in_byte & utf8d_pkg::LEAD3_MASK) == utf8d_pkg::LEAD3_PAT) begin
                n_seq_len = utf8d_pkg::SEQ_3;
                n_partial = {17'd0, r_in_byte[3:0]};
            end else if ((r_in_byte & utf8d_pkg::LEAD4_MASK) == utf8d_pkg::LEAD4_PAT) begin
                n_seq_len = utf8d_pkg::SEQ_4;
                n_partial = {18'd0, r_in_byte[2:0]};
            end else begin
                n_burst.tail_vld = 1'b1;
                n_burst.tail_cp  = utf8d_pkg::REPL_CHAR;
                n_burst.tail_rep = 1'b1;
            end
        end else begin
            // Accept a continuation byte
            n_partial = cont_pv;
            n_taken   = cont_taken;
            if (cont_last) begin
                n_seq_len = utf8d_pkg::SEQ_NONE;
                n_taken   = 2'd0;
                n_partial = '0;
                if (cont_ok) begin
                    n_burst.tail_vld = 1'b1;
                    n_burst.tail_cp  = cont_pv;
                end else begin
                    n_burst.rep_cnt = {1'b0, cont_taken} + 3'd1;
                end
            end
        end
    end

    // Advance input register, result register and decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_burst    <= '0;
            r_seq_len  <= utf8d_pkg::SEQ_NONE;
            r_taken    <= 2'd0;
            r_partial  <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
                r_in_byte  <= i_data_byte;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end

            if (move) begin
                r_burst   <= n_burst;
                r_seq_len <= n_seq_len;
                r_taken   <= n_taken;
                r_partial <= n_partial;
            end else if (out_take) begin
                if (r_burst.rep_cnt != 3'd0) begin
                    r_burst.rep_cnt <= r_burst.rep_cnt - 3'd1;
                end else begin
                    r_burst.tail_vld <= 1'b0;
                end
            end
        end
    end

endmodule

// ===== hw/rtl/utf8d_checker.sv =====
// ----------------------------------------------------------------------------
// UTF-8 decoder port checker
// Watches the decoder ports and flags inconsistent results or handshakes.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_with_replacement_macros.svh"

module utf8d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic [20:0] o_codepoint,
    input logic        o_replaced,
    input logic        o_end_of_string,
    input logic        i_stall
);

    // Hold a stalled result
    `U8D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_codepoint) && $stable(o_replaced) && $stable(o_end_of_string),
        "stalled result changed")

    // A replacement always carries U+FFFD and never ends the string
    `U8D_ASSERT_NOW(a_repl_value, i_clk, i_rst_n, o_valid && o_replaced,
        (o_codepoint == utf8d_pkg::REPL_CHAR) && !o_end_of_string,
        "bad replacement item")

    // The end marker carries code point zero
    `U8D_ASSERT_NOW(a_end_value, i_clk, i_rst_n, o_valid && o_end_of_string,
        (o_codepoint == '0) && !o_replaced, "bad end marker")

    // With no result pending, the input side never stalls
    `U8D_ASSERT_NOW(a_no_stall_idle, i_clk, i_rst_n, !o_valid, !o_stall,
        "input stalled while output empty")

    // Results stay within the Unicode range
    `U8D_ASSERT_NOW(a_cp_range, i_clk, i_rst_n, o_valid,
        o_codepoint <= utf8d_pkg::MAX_CP, "code point out of range")

endmodule

bind utf8_stream_decoder_with_replacement utf8d_checker u_utf8d_checker (.*);
